// ===== src/fixed_length_frame_deframer_macros.svh =====
// Assertion macros for the fixed-length frame deframer.
// Sampled on i_clk; the plain form is cut off while i_rst_n is low.
`ifndef FIXED_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define FIXED_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// Check a property outside reset
`define FLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define FLD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/fld_pkg.sv =====
// Shared types and constants for the fixed-length frame deframer.
// No dependencies; imported by the parser, the payload buffer and the checker.
package fld_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND_ON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND_ON = 3'd6;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH = 7'd16;
    localparam logic [BYTE_W-1:0] RST_HEAD_FIRST     = 8'h0D;
    localparam logic [BYTE_W-1:0] RST_HEAD_SECOND    = 8'h0A;
    localparam logic              RST_HEAD_SECOND_ON = 1'b1;
    localparam logic [BYTE_W-1:0] RST_TAIL_FIRST     = 8'h0A;
    localparam logic [BYTE_W-1:0] RST_TAIL_SECOND    = 8'h0D;
    localparam logic              RST_TAIL_SECOND_ON = 1'b1;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEAD2   = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TAIL1   = 3'd3,
        PH_TAIL2   = 3'd4
    } t_phase;

endpackage

// ===== src/fld_burst.sv =====
// Payload buffer and burst readout for the frame deframer.
// Depends on fld_pkg; holds the payload memory, the read sequencer and the output register.
module fld_burst
    import fld_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6,
    parameter int IW          = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_start,
    input  logic [IW-1:0]     i_count,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [POS_W-1:0]  o_payload_pos,
    output logic              o_last_of_frame
);

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_busy;
    logic [IW-1:0]     r_k;
    logic [IW-1:0]     r_n;
    logic              r_pend;
    logic [POS_W-1:0]  r_pend_pos;
    logic              r_pend_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    logic              rd_issue;
    logic [IW-1:0]     n_k;

    // Issue a read only when the output register is free by the time data returns
    assign rd_issue = r_busy && !r_pend && (!r_out_valid || !i_stall);
    assign n_k      = r_k + 1'b1;

    // Payload memory: one write port from the parser, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_k[AW-1:0]];
        end
    end

    // Advance the read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= rd_issue;
            if (i_start) begin
                r_busy <= (i_count != '0);
            end else if (rd_issue && (n_k == r_n)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Sequencer payload: word position and end-of-frame mark travel with the read
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k <= '0;
            r_n <= i_count;
        end else if (rd_issue) begin
            r_k <= n_k;
        end
        if (rd_issue) begin
            r_pend_pos  <= POS_W'(r_k);
            r_pend_last <= (n_k == r_n);
        end
    end

    // Output register: load the returned word, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out_byte <= r_rd_data;
            r_out_pos  <= r_pend_pos;
            r_out_last <= r_pend_last;
        end
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_pos   = r_out_pos;
    assign o_last_of_frame = r_out_last;

endmodule

// ===== src/fixed_length_frame_deframer.sv =====
// Fixed-length frame deframer: one received byte per input word. The parser
// takes a byte every cycle unless a burst stalls the input, while hunting for
// the header, storing the payload and checking the trailer. Payload bytes go
// straight into a registered-read memory of MAX_PAYLOAD entries. When the
// trailer matches, the input is stalled and the stored payload is read back
// as a burst of output words: per byte a memory read, then an output register
// load; a read waits out a pending load or i_stall. A frame's last burst word
// still waiting in the output register does not hold up the next input byte.
// The memory needs no clearing after reset: a burst only reads entries
// written in the same frame. Configuration is to be written while the block
// is idle; the block does not enforce it. Depends on fld_pkg and fld_burst.
module fixed_length_frame_deframer
    import fld_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // received bytes
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // payload words
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [POS_W-1:0]     o_payload_pos,
    output logic                 o_last_of_frame
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int IW = $clog2(MAX_PAYLOAD + 1);
    localparam int CW = (IW > LEN_W) ? IW : LEN_W;

    logic [LEN_W-1:0]  r_payload_length;
    logic [BYTE_W-1:0] r_head_first;
    logic [BYTE_W-1:0] r_head_second;
    logic              r_head_second_on;
    logic [BYTE_W-1:0] r_tail_first;
    logic [BYTE_W-1:0] r_tail_second;
    logic              r_tail_second_on;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;

    logic              accept;
    logic              busy;
    logic              wr_en;
    logic              start;
    logic              payload_done;

    assign accept = i_valid && !o_stall;
    assign o_stall = busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= RST_PAYLOAD_LENGTH;
            r_head_first     <= RST_HEAD_FIRST;
            r_head_second    <= RST_HEAD_SECOND;
            r_head_second_on <= RST_HEAD_SECOND_ON;
            r_tail_first     <= RST_TAIL_FIRST;
            r_tail_second    <= RST_TAIL_SECOND;
            r_tail_second_on <= RST_TAIL_SECOND_ON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data[LEN_W-1:0];
                CFG_HEAD_FIRST:     r_head_first     <= i_cfg_data;
                CFG_HEAD_SECOND:    r_head_second    <= i_cfg_data;
                CFG_HEAD_SECOND_ON: r_head_second_on <= i_cfg_data[0];
                CFG_TAIL_FIRST:     r_tail_first     <= i_cfg_data;
                CFG_TAIL_SECOND:    r_tail_second    <= i_cfg_data;
                CFG_TAIL_SECOND_ON: r_tail_second_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Payload ends at the configured length or at the buffer size. The count
    // is at least one after a store, so a zero length acts as one, and the
    // buffer-size test covers lengths above it.
    assign payload_done = (CW'(n_idx) >= CW'(r_payload_length)) ||
                          (n_idx >= IW'(MAX_PAYLOAD));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_head_first) begin
                        n_phase = r_head_second_on ? PH_HEAD2 : PH_PAYLOAD;
                    end
                end
                PH_HEAD2: begin
                    if (i_rx_byte == r_head_second) begin
                        n_phase = PH_PAYLOAD;
                    end else if (i_rx_byte != r_head_first) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (payload_done) begin
                        n_phase = PH_TAIL1;
                    end
                end
                PH_TAIL1: begin
                    if (i_rx_byte == r_tail_first && r_tail_second_on) begin
                        n_phase = PH_TAIL2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_TAIL2: n_phase = PH_HUNT;
                default:  n_phase = PH_HUNT;
            endcase
        end
    end

    // Store, count and burst start
    always_comb begin
        wr_en = 1'b0;
        start = 1'b0;
        n_idx = r_idx;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: n_idx = '0;
                PH_PAYLOAD: begin
                    if (r_idx < IW'(MAX_PAYLOAD)) begin
                        wr_en = 1'b1;
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_TAIL1: start = (i_rx_byte == r_tail_first) && !r_tail_second_on;
                PH_TAIL2: start = (i_rx_byte == r_tail_second);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // Payload buffer and burst output
    fld_burst #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .IW          (IW)
    ) u_burst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (wr_en),
        .i_wr_addr       (r_idx[AW-1:0]),
        .i_wr_data       (i_rx_byte),
        .i_start         (start),
        .i_count         (r_idx),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_pos   (o_payload_pos),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== src/fld_checker.sv =====
// Port-level checks for the fixed-length frame deframer.
// Depends on fld_pkg and fixed_length_frame_deframer_macros.svh; bound to the top level.
`include "fixed_length_frame_deframer_macros.svh"

module fld_checker
    import fld_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [BYTE_W-1:0]    o_payload_byte,
    input logic [POS_W-1:0]     o_payload_pos,
    input logic                 o_last_of_frame
);

    // A stalled output word holds
    `FLD_ASSERT(a_out_hold,
        o_valid && i_stall |=>
            o_valid && $stable({o_payload_byte, o_payload_pos, o_last_of_frame}),
        "output word changed while stalled")

    // Mid-burst words mean the burst is still running, so input is held off
    `FLD_ASSERT(a_burst_blocks_input,
        o_valid && !o_last_of_frame |-> o_stall,
        "input open during a burst")

    // No output word right after reset
    `FLD_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "output word after reset")

    // Consecutive words of a burst carry different positions
    `FLD_ASSERT(a_pos_step,
        o_valid && !i_stall && !o_last_of_frame ##1 o_valid |->
            o_payload_pos != $past(o_payload_pos),
        "burst position did not advance")

endmodule

bind fixed_length_frame_deframer fld_checker u_fld_checker (.*);

// ===== bench/fixed_length_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_length_frame_deframer: directed frames, then random framed
// traffic under changing header, trailer and length settings. Depends on fld_pkg and the RTL.
module fixed_length_frame_deframer_test;
    import fld_pkg::*;

    localparam int FRAME_MAX     = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SEGMENTS      = 10;
    localparam int SEGMENT_WORDS = 50;
    localparam int IDLE_PCT      = 18;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HEAD2,
        FR_BAD_TAIL1,
        FR_BAD_TAIL2,
        FR_REPEAT_HEAD
    } t_frame_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              is_last;
    } t_payload_word;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [POS_W-1:0]     o_payload_pos;
    logic                 o_last_of_frame;

    // Register copies and parser state of the predictor
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] head1_reg;
    logic [BYTE_W-1:0] head2_reg;
    logic              head2_en;
    logic [BYTE_W-1:0] tail1_reg;
    logic [BYTE_W-1:0] tail2_reg;
    logic              tail2_en;
    t_phase            phase;
    logic [LEN_W-1:0]  stored_count;
    logic [BYTE_W-1:0] frame_store [FRAME_MAX];

    t_byte_q         rx_backlog;
    t_payload_word   expected_words[$];
    t_payload_word   want;
    logic            rx_taken;
    logic            calm;
    int              cycle_count;
    int              rx_words;
    int              checked_words;
    int              checked_frames;
    int              reg_writes;
    int              word_mismatches;

    fixed_length_frame_deframer #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_payload_pos  (o_payload_pos),
        .o_last_of_frame(o_last_of_frame)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Payload length actually in force: zero acts as one, anything above the store size saturates
    function automatic int clamped_length();
        if (len_reg == 0) return 1;
        if (len_reg > FRAME_MAX) return FRAME_MAX;
        return int'(len_reg);
    endfunction

    // Random byte guaranteed to miss the given framing byte
    function automatic logic [BYTE_W-1:0] differ(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        if (r == v) r = ~v;
        return r;
    endfunction

    // Queue the stored payload as one burst, last word marked
    function automatic void deliver_frame();
        for (int k = 0; k < int'(stored_count); k++) begin
            expected_words.push_back('{frame_store[k], POS_W'(k),
                                       k == int'(stored_count) - 1});
        end
    endfunction

    // Advance the parser by one received byte
    function automatic void deframe_byte(input logic [BYTE_W-1:0] rx);
        case (phase)
            PH_HUNT: begin
                if (rx == head1_reg) phase = head2_en ? PH_HEAD2 : PH_PAYLOAD;
                stored_count = '0;
            end
            PH_HEAD2: begin
                if (rx == head2_reg) phase = PH_PAYLOAD;
                else if (rx == head1_reg) phase = PH_HEAD2;
                else phase = PH_HUNT;
            end
            PH_PAYLOAD: begin
                if (stored_count < FRAME_MAX) begin
                    frame_store[stored_count] = rx;
                    stored_count = stored_count + 1'b1;
                end
                if (stored_count >= clamped_length()) phase = PH_TAIL1;
            end
            PH_TAIL1: begin
                if (rx != tail1_reg) begin
                    phase = PH_HUNT;
                end else if (tail2_en) begin
                    phase = PH_TAIL2;
                end else begin
                    phase = PH_HUNT;
                    deliver_frame();
                end
            end
            PH_TAIL2: begin
                phase = PH_HUNT;
                if (rx == tail2_reg) deliver_frame();
            end
            default: phase = PH_HUNT;
        endcase
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        reg_writes++;
        case (idx)
            CFG_PAYLOAD_LENGTH: len_reg   = value[LEN_W-1:0];
            CFG_HEAD_FIRST:     head1_reg = value;
            CFG_HEAD_SECOND:    head2_reg = value;
            CFG_HEAD_SECOND_ON: head2_en  = value[0];
            CFG_TAIL_FIRST:     tail1_reg = value;
            CFG_TAIL_SECOND:    tail2_reg = value;
            CFG_TAIL_SECOND_ON: tail2_en  = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Build one frame for the current settings, optionally broken
    task automatic build_frame(input t_frame_kind kind, output t_byte_q seq);
        int pick;
        seq = {};
        seq.push_back(head1_reg);
        if (kind == FR_REPEAT_HEAD) repeat ($urandom_range(1, 3)) seq.push_back(head1_reg);
        if (head2_en) seq.push_back(kind == FR_BAD_HEAD2 ? differ(head2_reg) : head2_reg);
        for (int k = 0; k < clamped_length(); k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) seq.push_back(tail1_reg);
            else if (pick == 1) seq.push_back(head1_reg);
            else seq.push_back(BYTE_W'($urandom));
        end
        seq.push_back(kind == FR_BAD_TAIL1 ? differ(tail1_reg) : tail1_reg);
        if (tail2_en) seq.push_back(kind == FR_BAD_TAIL2 ? differ(tail2_reg) : tail2_reg);
    endtask

    // Wait until every queued word is in and every burst is out, then let the block settle
    task automatic drain_and_settle();
        while (rx_backlog.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: present the next word once the current one is taken; idle and stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || rx_taken) begin
            if (rx_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_valid   <= 1'b1;
                i_rx_byte <= rx_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: predict on accepted input words, check accepted payload words
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d payload words outstanding",
                     cycle_count, expected_words.size());
            $display("fixed_length_frame_deframer regression: fail");
            $finish;
        end else begin
            rx_taken <= i_valid && !o_stall;
            if (i_rst_n && i_valid && !o_stall) begin
                deframe_byte(i_rx_byte);
                rx_words++;
            end
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    word_mismatches++;
                    if (word_mismatches <= MAX_REPORTS)
                        $display("unexpected payload word: byte %02h pos %0d last %0b",
                                 o_payload_byte, o_payload_pos, o_last_of_frame);
                end else begin
                    want = expected_words.pop_front();
                    checked_words++;
                    if (want.is_last) checked_frames++;
                    if (o_payload_byte !== want.data || o_payload_pos !== want.pos ||
                        o_last_of_frame !== want.is_last) begin
                        word_mismatches++;
                        if (word_mismatches <= MAX_REPORTS)
                            $display({"payload word %0d: expected byte %02h pos %0d last %0b,",
                                      " got byte %02h pos %0d last %0b"},
                                     checked_words, want.data, want.pos, want.is_last,
                                     o_payload_byte, o_payload_pos, o_last_of_frame);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_byte_q           frame_bytes;
        t_frame_kind       kind;
        int                pick;
        int                seg_words;
        int                cut;
        logic [BYTE_W-1:0] value;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_rx_byte  = '0;
        rx_taken   = 1'b0;
        calm       = 1'b0;
        len_reg    = RST_PAYLOAD_LENGTH;
        head1_reg  = RST_HEAD_FIRST;
        head2_reg  = RST_HEAD_SECOND;
        head2_en   = RST_HEAD_SECOND_ON;
        tail1_reg  = RST_TAIL_FIRST;
        tail2_reg  = RST_TAIL_SECOND;
        tail2_en   = RST_TAIL_SECOND_ON;
        phase      = PH_HUNT;
        stored_count = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: repeated first header, then a full frame carrying byte extremes
        rx_backlog.push_back(head1_reg);
        rx_backlog.push_back(head1_reg);
        rx_backlog.push_back(head2_reg);
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h55);
        rx_backlog.push_back(8'hAA);
        repeat (clamped_length() - 4) rx_backlog.push_back(BYTE_W'($urandom));
        rx_backlog.push_back(tail1_reg);
        rx_backlog.push_back(tail2_reg);
        drain_and_settle();

        // Single-byte framing, zero length acting as one
        write_reg(CFG_PAYLOAD_LENGTH, 8'h00);
        write_reg(CFG_HEAD_SECOND_ON, 8'hFE);
        write_reg(CFG_TAIL_SECOND_ON, 8'hFE);
        write_reg(CFG_HEAD_FIRST, 8'hFF);
        write_reg(CFG_TAIL_FIRST, 8'h00);
        rx_backlog = {8'hFF, 8'h00, 8'h00};
        // A bad trailer byte equal to the header must not open a new frame
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h11);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h22);
        rx_backlog.push_back(8'h00);
        drain_and_settle();

        // Random segments, each under its own register settings
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            for (int idx = 0; idx <= int'(CFG_UNUSED); idx++) begin
                if (seg == 0 || $urandom_range(0, 99) < 40) begin
                    pick = $urandom_range(0, 19);
                    case (CFG_IDX_W'(idx))
                        CFG_PAYLOAD_LENGTH: begin
                            if (seg == 2) value = BYTE_W'(FRAME_MAX);
                            else if (pick == 0) value = 8'h00;
                            else if (pick == 1) value = 8'h80 | BYTE_W'($urandom_range(65, 127));
                            else if (pick == 2) value = BYTE_W'($urandom_range(65, 127));
                            else value = BYTE_W'($urandom_range(1, 12) | ($urandom_range(0, 1) << 7));
                        end
                        CFG_HEAD_FIRST, CFG_HEAD_SECOND, CFG_TAIL_FIRST, CFG_TAIL_SECOND: begin
                            if (pick == 0) value = 8'h00;
                            else if (pick == 1) value = 8'hFF;
                            else value = BYTE_W'($urandom);
                        end
                        default: value = BYTE_W'($urandom);
                    endcase
                    write_reg(CFG_IDX_W'(idx), value);
                end
            end
            calm = (seg == 5);

            // Mostly well-formed frames, some noise and broken frames
            seg_words = 0;
            while (seg_words < SEGMENT_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        rx_backlog.push_back(BYTE_W'($urandom));
                        seg_words++;
                    end
                end else begin
                    if (pick < 72) kind = FR_GOOD;
                    else if (pick < 80) kind = FR_BAD_HEAD2;
                    else if (pick < 88) kind = FR_BAD_TAIL1;
                    else if (pick < 94) kind = FR_BAD_TAIL2;
                    else kind = FR_REPEAT_HEAD;
                    build_frame(kind, frame_bytes);
                    foreach (frame_bytes[k]) rx_backlog.push_back(frame_bytes[k]);
                    seg_words += frame_bytes.size();
                end
            end

            // Leave a frame half done so the next settings change lands mid-frame
            if ($urandom_range(0, 1)) begin
                build_frame(FR_GOOD, frame_bytes);
                cut = $urandom_range(1, frame_bytes.size() - 1);
                for (int k = 0; k < cut; k++) rx_backlog.push_back(frame_bytes[k]);
            end
            drain_and_settle();
            calm = 1'b0;
        end

        $display("Fed %0d received words under %0d register writes over %0d segments.",
                 rx_words, reg_writes, SEGMENTS);
        $display("Checked %0d payload words in %0d frames, %0d mismatches.",
                 checked_words, checked_frames, word_mismatches);
        if (word_mismatches == 0 && expected_words.size() == 0) begin
            $display("fixed_length_frame_deframer regression: pass");
        end else begin
            $display("fixed_length_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
